@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL files.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define VFC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define VFC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/vfc_pkg.sv @@
// Shared types, constants and the CORDIC angle table of the footprint block.
// No dependencies.
package vfc_pkg;

   localparam int CORDIC_STAGES_DEF = 16;
   localparam int XY_W   = 34;
   localparam int Z_W    = 33;
   localparam int CS_W   = 18;
   localparam int LX_W   = 18;
   localparam int LY_W   = 17;
   localparam int CSR_IDX_W = 8;
   localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);
   localparam logic signed [24:0] POS_MAX = 25'sd8388607;
   localparam logic signed [24:0] POS_MIN = -25'sd8388608;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TRACTOR_LENGTH = 8'd0,
      REG_TRACTOR_WIDTH  = 8'd1,
      REG_TRAILER_LENGTH = 8'd2,
      REG_TRAILER_WIDTH  = 8'd3
   } reg_index_type;

   typedef struct packed {
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
      logic [15:0]        tractor_heading;
      logic [15:0]        trailer_heading;
   } req_type;

   typedef struct packed {
      logic signed [23:0] corner_x;
      logic signed [23:0] corner_y;
      logic               body_index;
      logic [1:0]         corner_index;
      logic               last_corner;
   } rsp_type;

   typedef struct packed {
      logic [15:0] tractor_length;
      logic [15:0] tractor_width;
      logic [15:0] trailer_length;
      logic [15:0] trailer_width;
   } cfg_type;

   // Corner data that rides along the rotation chain.
   typedef struct packed {
      logic signed [23:0]     px;
      logic signed [23:0]     py;
      logic signed [LX_W-1:0] lx;
      logic signed [LY_W-1:0] ly;
      logic                   body;
      logic [1:0]             corner;
      logic                   last;
   } carry_type;

   typedef struct packed {
      logic                   valid;
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      logic [1:0]             quad;
      carry_type              carry;
   } token_type;

   // Arctangent of 2^-i in units of 2^32 per turn.
   function automatic logic [31:0] atan_turn(input int idx);
      logic [31:0] v;
      case (idx)
         0:  v = 32'd536870912;
         1:  v = 32'd316933406;
         2:  v = 32'd167458907;
         3:  v = 32'd85004756;
         4:  v = 32'd42667331;
         5:  v = 32'd21354465;
         6:  v = 32'd10679838;
         7:  v = 32'd5340245;
         8:  v = 32'd2670163;
         9:  v = 32'd1335087;
         10: v = 32'd667544;
         11: v = 32'd333772;
         12: v = 32'd166886;
         13: v = 32'd83443;
         14: v = 32'd41722;
         15: v = 32'd20861;
         16: v = 32'd10430;
         17: v = 32'd5215;
         18: v = 32'd2608;
         19: v = 32'd1304;
         20: v = 32'd652;
         21: v = 32'd326;
         22: v = 32'd163;
         23: v = 32'd81;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

@@ rtl/vfc_seq.sv @@
// Corner sequencer: holds the pose and issues one corner token per cycle.
// Depends on vfc_pkg.
module vfc_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  vfc_pkg::req_type  req_data,
   input  vfc_pkg::cfg_type  cfg,
   output vfc_pkg::token_type token
);

   logic              active_ff, active_in;
   logic [2:0]        count_ff, count_in;
   vfc_pkg::req_type  pose_ff, pose_in;
   logic              accept;
   logic [2:0]        idx;
   logic [2:0]        last_idx;
   vfc_pkg::req_type  pose;
   logic [15:0]       heading;
   logic [15:0]       hsum;
   logic [1:0]        quad;
   logic [15:0]       resid;
   logic [15:0]       half_w;
   logic              body;
   logic [1:0]        corner;

   assign accept = start & ~busy;
   assign busy   = active_ff;

   // Slot index and pose of the corner issued this cycle.
   always_comb begin
      idx      = accept ? 3'd0 : count_ff;
      pose     = accept ? req_data : pose_ff;
      last_idx = (cfg.trailer_length != 16'd0) ? 3'd7 : 3'd3;
      body     = idx[2];
      corner   = idx[1:0];
   end

   // Advance through the four or eight corners of a pose.
   always_comb begin
      active_in = active_ff;
      count_in  = count_ff;
      pose_in   = pose;
      if (accept || active_ff) begin
         if (idx == last_idx) begin
            active_in = 1'b0;
            count_in  = 3'd0;
         end else begin
            active_in = 1'b1;
            count_in  = idx + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         count_ff  <= 3'd0;
      end else begin
         active_ff <= active_in;
         count_ff  <= count_in;
      end
      pose_ff <= pose_in;
   end

   // Quadrant fold, body-frame corner and the first chain token.
   always_comb begin
      heading = body ? pose.trailer_heading : pose.tractor_heading;
      hsum    = heading + 16'h2000;
      quad    = hsum[15:14];
      resid   = heading - {quad, 14'd0};
      half_w  = body ? cfg.trailer_width : cfg.tractor_width;

      token.valid = accept | active_ff;
      token.x     = vfc_pkg::CORDIC_GAIN;
      token.y     = '0;
      token.z     = vfc_pkg::Z_W'($signed({resid, 16'd0}));
      token.quad  = quad;
      token.carry.px     = pose.pos_x;
      token.carry.py     = pose.pos_y;
      token.carry.body   = body;
      token.carry.corner = corner;
      token.carry.last   = (idx == last_idx);
      if (!body) begin
         token.carry.lx = (corner < 2'd2) ?
            $signed({1'b0, cfg.tractor_length, 1'b0}) : '0;
      end else begin
         token.carry.lx = (corner < 2'd2) ?
            '0 : -$signed({1'b0, cfg.trailer_length, 1'b0});
      end
      if (corner == 2'd1 || corner == 2'd2) begin
         token.carry.ly = $signed({1'b0, half_w});
      end else begin
         token.carry.ly = -$signed({1'b0, half_w});
      end
   end

endmodule

@@ rtl/vfc_cell.sv @@
// One CORDIC rotation cell: a micro-rotation by atan(2^-STAGE) per cycle.
// Depends on vfc_pkg.
module vfc_cell #(
   parameter int STAGE = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  vfc_pkg::token_type tok_in,
   output vfc_pkg::token_type tok_out
);

   localparam logic signed [vfc_pkg::Z_W-1:0] ATAN =
      vfc_pkg::Z_W'(vfc_pkg::atan_turn(STAGE));

   vfc_pkg::token_type tok_ff, tok_in_next;
   logic signed [vfc_pkg::XY_W-1:0] dx, dy;

   // Rotate toward zero residual angle.
   always_comb begin
      dx = tok_in.y >>> STAGE;
      dy = tok_in.x >>> STAGE;
      tok_in_next = tok_in;
      if (!tok_in.z[vfc_pkg::Z_W-1]) begin
         tok_in_next.x = tok_in.x - dx;
         tok_in_next.y = tok_in.y + dy;
         tok_in_next.z = tok_in.z - ATAN;
      end else begin
         tok_in_next.x = tok_in.x + dx;
         tok_in_next.y = tok_in.y - dy;
         tok_in_next.z = tok_in.z + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in_next.valid;
      end
      tok_ff.x     <= tok_in_next.x;
      tok_ff.y     <= tok_in_next.y;
      tok_ff.z     <= tok_in_next.z;
      tok_ff.quad  <= tok_in_next.quad;
      tok_ff.carry <= tok_in_next.carry;
   end

   assign tok_out = tok_ff;

endmodule

@@ rtl/vfc_rotate.sv @@
// Corner transform: rounds sin/cos, rotates the body-frame corner,
// moves it to the hitch and saturates. Depends on vfc_pkg.
module vfc_rotate (
   input  logic               clock,
   input  logic               reset,
   input  vfc_pkg::token_type tok,
   output logic               rsp_valid,
   output vfc_pkg::rsp_type   rsp_data
);

   localparam int P_W = vfc_pkg::LX_W + vfc_pkg::CS_W;

   logic signed [vfc_pkg::XY_W-1:0] xr, yr;
   logic signed [vfc_pkg::CS_W-1:0] cr, sr;
   logic signed [vfc_pkg::CS_W-1:0] c_ff, c_in, s_ff, s_in;
   logic                            v1_ff, v2_ff, v_out_ff;
   vfc_pkg::carry_type              k1_ff, k2_ff;
   logic signed [P_W-1:0] lxc_ff, lxs_ff, lyc_ff, lys_ff;
   logic signed [P_W:0]   sum_x, sum_y;
   logic signed [24:0]    wx, wy;
   logic signed [24:0]    ax, ay;
   vfc_pkg::rsp_type      rsp_ff, rsp_in;

   // Round the CORDIC outputs to Q1.16 and unfold the quadrant.
   always_comb begin
      xr = (tok.x + vfc_pkg::XY_W'(8192)) >>> 14;
      yr = (tok.y + vfc_pkg::XY_W'(8192)) >>> 14;
      cr = xr[vfc_pkg::CS_W-1:0];
      sr = yr[vfc_pkg::CS_W-1:0];
      case (tok.quad)
         2'd0: begin c_in = cr;  s_in = sr;  end
         2'd1: begin c_in = -sr; s_in = cr;  end
         2'd2: begin c_in = -cr; s_in = -sr; end
         default: begin c_in = sr; s_in = -cr; end
      endcase
   end

   // Sum of products, rounding to Q.8, translation and saturation.
   always_comb begin
      sum_x = (P_W+1)'(lxc_ff) - (P_W+1)'(lys_ff) + (P_W+1)'(65536);
      sum_y = (P_W+1)'(lxs_ff) + (P_W+1)'(lyc_ff) + (P_W+1)'(65536);
      wx    = 25'(sum_x >>> 17);
      wy    = 25'(sum_y >>> 17);
      ax    = 25'(k2_ff.px) + wx;
      ay    = 25'(k2_ff.py) + wy;
      if (ax > vfc_pkg::POS_MAX)      rsp_in.corner_x = 24'sh7FFFFF;
      else if (ax < vfc_pkg::POS_MIN) rsp_in.corner_x = 24'sh800000;
      else                            rsp_in.corner_x = ax[23:0];
      if (ay > vfc_pkg::POS_MAX)      rsp_in.corner_y = 24'sh7FFFFF;
      else if (ay < vfc_pkg::POS_MIN) rsp_in.corner_y = 24'sh800000;
      else                            rsp_in.corner_y = ay[23:0];
      rsp_in.body_index   = k2_ff.body;
      rsp_in.corner_index = k2_ff.corner;
      rsp_in.last_corner  = k2_ff.last;
   end

   // Three registered steps: sin/cos, products, result.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v_out_ff <= 1'b0;
      end else begin
         v1_ff    <= tok.valid;
         v2_ff    <= v1_ff;
         v_out_ff <= v2_ff;
      end
      c_ff   <= c_in;
      s_ff   <= s_in;
      k1_ff  <= tok.carry;
      lxc_ff <= P_W'(k1_ff.lx) * P_W'(c_ff);
      lxs_ff <= P_W'(k1_ff.lx) * P_W'(s_ff);
      lyc_ff <= P_W'(k1_ff.ly) * P_W'(c_ff);
      lys_ff <= P_W'(k1_ff.ly) * P_W'(s_ff);
      k2_ff  <= k1_ff;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = v_out_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ rtl/vehicle_footprint_corners.sv @@
// Top level of the hooked-vehicle footprint corner generator.
// Depends on vfc_pkg, vfc_seq, vfc_cell, vfc_rotate and assert_macros.svh.
//
//   channel  ports                            direction
//   request  start, busy, req_data            in, pose items
//   result   rsp_valid, rsp_data              out, one corner item a cycle
//   config   csr_valid, csr_ready, csr_index, csr_data   in, register writes
//
// A pose gives four corner items, or eight when trailer_length is nonzero,
// one per cycle; busy stays high until its last corner has been issued, so a
// pose is taken only after the last corner of the one before. Each corner
// passes through CORDIC_STAGES rotation cells and three transform registers.
// Reset is synchronous and clears the control state, the valid flags and the
// configuration but not the data registers. The receiver cannot stall.
`include "assert_macros.svh"

module vehicle_footprint_corners #(
   parameter int CORDIC_STAGES = vfc_pkg::CORDIC_STAGES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  vfc_pkg::req_type              req_data,
   output logic                          rsp_valid,
   output vfc_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [vfc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]                   csr_data
);

   vfc_pkg::cfg_type   cfg_ff, cfg_in;
   vfc_pkg::token_type chain [0:CORDIC_STAGES];

   assign csr_ready = 1'b1;

   // Register writes; an index beyond the list is dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            vfc_pkg::REG_TRACTOR_LENGTH: cfg_in.tractor_length = csr_data;
            vfc_pkg::REG_TRACTOR_WIDTH:  cfg_in.tractor_width  = csr_data;
            vfc_pkg::REG_TRAILER_LENGTH: cfg_in.trailer_length = csr_data;
            vfc_pkg::REG_TRAILER_WIDTH:  cfg_in.trailer_width  = csr_data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Corner issue.
   vfc_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .cfg      (cfg_ff),
      .token    (chain[0])
   );

   // Row of rotation cells.
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      vfc_cell #(.STAGE(i)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .tok_in  (chain[i]),
         .tok_out (chain[i+1])
      );
   end

   // Rotation, translation and saturation of each corner.
   vfc_rotate u_rotate (
      .clock     (clock),
      .reset     (reset),
      .tok       (chain[CORDIC_STAGES]),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // Every pose issues at least four corners, so busy follows an accept.
   `VFC_ASSERT_NEXT(a_busy_after_accept, clock, reset, start && !busy, busy)
   // The closing corner of a pose is always a rear-right corner.
   `VFC_ASSERT_NOW(a_last_is_rear_right, clock, reset,
      rsp_valid && rsp_data.last_corner, rsp_data.corner_index == 2'd3)
   // A trailer corner is never the first corner of a pose stream.
   `VFC_ASSERT_NOW(a_trailer_follows_tractor, clock, reset,
      rsp_valid && rsp_data.body_index && rsp_data.corner_index == 2'd0,
      $past(rsp_valid) && !$past(rsp_data.body_index))

endmodule
